[rtl/core/bdq_pkg.sv]
`default_nettype none

package bdq_pkg;

    // default geometry
    localparam int DEF_DEPTH = 64;
    localparam int DATA_W    = 32;

    // request codes
    typedef enum logic [3:0] {
        CMD_PUSH_BACK  = 4'd0,
        CMD_PUSH_FRONT = 4'd1,
        CMD_POP_BACK   = 4'd2,
        CMD_POP_FRONT  = 4'd3,
        CMD_FIND_FRONT = 4'd4,
        CMD_FIND_BACK  = 4'd5,
        CMD_REMOVE     = 4'd6,
        CMD_INSERT     = 4'd7,
        CMD_CLEAR      = 4'd8
    } t_cmd;

    // result status codes
    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_BADPOS   = 3'd4
    } t_status;

endpackage

`default_nettype wire

[rtl/core/bounded_deque_with_search.sv]
`default_nettype none

// Bounded deque of signed 32-bit words kept in a single-port-write, single-port-read ring
// memory of DEPTH words. One request is taken at a time; o_in_ready is low until its
// result has been loaded into the output register. Find, remove and insert walk the
// memory through its one read port, one entry per cycle, with the walk overlapped with
// the shift writes; find stops early when it hits. Clear, and any request turned away
// as empty, full or bad position, does not walk the memory. The memory needs no
// clearing pass after reset: only written entries are ever read. A result waiting in the
// output register does not stop a new request from being accepted.
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_cmd,
    input  wire logic [31:0] i_data_in,
    input  wire logic [6:0]  i_position,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_data_out,
    output logic [5:0]       o_found_index,
    output logic [2:0]       o_status,
    output logic [6:0]       o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state            r_state,     n_state;
    t_cmd              r_cmd,       n_cmd;
    logic [31:0]       r_val,       n_val;
    logic [6:0]        r_pos,       n_pos;
    logic [AW-1:0]     r_head,      n_head;
    logic [CW-1:0]     r_count,     n_count;
    logic [AW-1:0]     r_idx,       n_idx;
    logic [CW-1:0]     r_left,      n_left;
    logic              r_pend,      n_pend;
    logic [AW-1:0]     r_pend_idx,  n_pend_idx;
    logic [AW-1:0]     r_pend_slot, n_pend_slot;
    logic [AW-1:0]     r_last_slot, n_last_slot;
    logic              r_first,     n_first;
    logic [31:0]       r_dout,      n_dout;
    logic [AW-1:0]     r_fidx,      n_fidx;
    t_status           r_st,        n_st;
    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_out_data,  n_out_data;
    logic [AW-1:0]     r_out_fidx,  n_out_fidx;
    t_status           r_out_st,    n_out_st;
    logic [CW-1:0]     r_out_count, n_out_count;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [31:0]       w_wdata;
    logic [31:0]       w_rdata;
    logic [AW-1:0]     w_slot_idx;
    logic [AW-1:0]     w_slot;
    logic [AW-1:0]     w_head_dec;
    logic [AW-1:0]     w_head_inc;
    logic              w_full;
    logic              w_empty;
    logic              w_down;
    logic [PW-1:0]     w_pos_ext;
    logic [PW-1:0]     w_cnt_ext;

    // ring storage and the shared slot address unit
    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_slot),
        .o_rdata (w_rdata)
    );

    bdq_slot #(
        .DEPTH (DEPTH)
    ) u_slot (
        .i_head  (r_head),
        .i_index (w_slot_idx),
        .o_slot  (w_slot)
    );

    // decode helpers
    assign w_slot_idx = (r_state == S_EXEC) ? AW'(r_count) : r_idx;
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_down     = (r_cmd == CMD_FIND_BACK) || (r_cmd == CMD_INSERT);
    assign w_pos_ext  = PW'(r_pos);
    assign w_cnt_ext  = PW'(r_count);

    // sequencer and walk datapath
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_pos       = r_pos;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_left      = r_left;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_pend_slot = r_pend_slot;
        n_last_slot = r_last_slot;
        n_first     = r_first;
        n_dout      = r_dout;
        n_fidx      = r_fidx;
        n_st        = r_st;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_fidx  = r_out_fidx;
        n_out_st    = r_out_st;
        n_out_count = r_out_count;
        w_we        = 1'b0;
        w_waddr     = r_last_slot;
        w_wdata     = r_val;

        // drop the result once taken
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_val   = i_data_in;
                    n_pos   = i_position;
                    n_dout  = '0;
                    n_fidx  = '0;
                    n_st    = STAT_OK;
                    n_pend  = 1'b0;
                    n_left  = '0;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_PUSH_BACK: begin
                        if (w_full) begin
                            n_st = STAT_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_slot;
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_PUSH_FRONT: begin
                        if (w_full) begin
                            n_st = STAT_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_head_dec;
                            n_head  = w_head_dec;
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_POP_BACK: begin
                        if (w_empty) begin
                            n_st = STAT_EMPTY;
                        end else begin
                            n_idx   = AW'(r_count - CW'(1));
                            n_left  = CW'(1);
                            n_state = S_SCAN;
                        end
                    end
                    CMD_POP_FRONT: begin
                        if (w_empty) begin
                            n_st = STAT_EMPTY;
                        end else begin
                            n_idx   = '0;
                            n_left  = CW'(1);
                            n_state = S_SCAN;
                        end
                    end
                    CMD_FIND_FRONT: begin
                        if (w_empty) begin
                            n_st = STAT_EMPTY;
                        end else begin
                            n_st    = STAT_NOTFOUND;
                            n_idx   = '0;
                            n_left  = r_count;
                            n_state = S_SCAN;
                        end
                    end
                    CMD_FIND_BACK: begin
                        if (w_empty) begin
                            n_st = STAT_EMPTY;
                        end else begin
                            n_st    = STAT_NOTFOUND;
                            n_idx   = AW'(r_count - CW'(1));
                            n_left  = r_count;
                            n_state = S_SCAN;
                        end
                    end
                    CMD_REMOVE: begin
                        if (w_empty) begin
                            n_st = STAT_EMPTY;
                        end else if (w_pos_ext >= w_cnt_ext) begin
                            n_st = STAT_BADPOS;
                        end else begin
                            n_idx   = AW'(r_pos);
                            n_left  = CW'(w_cnt_ext - w_pos_ext);
                            n_first = 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                    CMD_INSERT: begin
                        if (w_full) begin
                            n_st = STAT_FULL;
                        end else if (w_pos_ext > w_cnt_ext) begin
                            n_st = STAT_BADPOS;
                        end else begin
                            // first shift lands in the slot just past the back
                            n_last_slot = w_slot;
                            n_idx       = AW'(r_count - CW'(1));
                            n_left      = CW'(w_cnt_ext - w_pos_ext);
                            n_state     = S_SCAN;
                        end
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                        n_head  = '0;
                    end
                    default: begin
                    end
                endcase
            end

            S_SCAN: begin
                // issue the next read of the walk
                if (r_left != '0) begin
                    n_pend      = 1'b1;
                    n_pend_idx  = r_idx;
                    n_pend_slot = w_slot;
                    n_left      = r_left - CW'(1);
                    n_idx       = w_down ? r_idx - AW'(1) : r_idx + AW'(1);
                end else begin
                    n_pend = 1'b0;
                end

                // consume the word read in the previous cycle
                if (r_pend) begin
                    case (r_cmd)
                        CMD_POP_BACK, CMD_POP_FRONT: begin
                            n_dout = w_rdata;
                        end
                        CMD_FIND_FRONT, CMD_FIND_BACK: begin
                            if (w_rdata == r_val) begin
                                n_st    = STAT_OK;
                                n_fidx  = r_pend_idx;
                                n_pend  = 1'b0;
                                n_state = S_DONE;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_first) begin
                                n_dout = w_rdata;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_last_slot;
                                w_wdata = w_rdata;
                            end
                            n_last_slot = r_pend_slot;
                            n_first     = 1'b0;
                        end
                        CMD_INSERT: begin
                            w_we        = 1'b1;
                            w_waddr     = r_last_slot;
                            w_wdata     = w_rdata;
                            n_last_slot = r_pend_slot;
                        end
                        default: begin
                        end
                    endcase
                end

                // walk over: commit count and head, and write the inserted value
                if ((r_left == '0) && !r_pend) begin
                    n_state = S_DONE;
                    case (r_cmd)
                        CMD_POP_BACK, CMD_REMOVE: begin
                            n_count = r_count - CW'(1);
                        end
                        CMD_POP_FRONT: begin
                            n_count = r_count - CW'(1);
                            n_head  = w_head_inc;
                        end
                        CMD_INSERT: begin
                            w_we    = 1'b1;
                            w_waddr = r_last_slot;
                            w_wdata = r_val;
                            n_count = r_count + CW'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_DONE: begin
                // load the result once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_dout;
                    n_out_fidx  = r_fidx;
                    n_out_st    = r_st;
                    n_out_count = r_count;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_val       <= n_val;
            r_pos       <= n_pos;
            r_head      <= n_head;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_pend_idx  <= n_pend_idx;
            r_pend_slot <= n_pend_slot;
            r_last_slot <= n_last_slot;
            r_first     <= n_first;
            r_dout      <= n_dout;
            r_fidx      <= n_fidx;
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
            r_out_data  <= n_out_data;
            r_out_fidx  <= n_out_fidx;
            r_out_st    <= n_out_st;
            r_out_count <= n_out_count;
        end
    end

    // ports
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_data_out    = r_out_data;
    assign o_found_index = 6'(r_out_fidx);
    assign o_status      = r_out_st;
    assign o_entry_count = 7'(r_out_count);

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("memory written while idle");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted request not decoded");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

endmodule

`default_nettype wire

[rtl/core/bdq_ram.sv]
`default_nettype none

module bdq_ram
    import bdq_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = DEF_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/bdq_slot.sv]
`default_nettype none

module bdq_slot
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input  wire logic [$clog2(DEPTH)-1:0] i_head,
    input  wire logic [$clog2(DEPTH)-1:0] i_index,
    output logic      [$clog2(DEPTH)-1:0] o_slot
);

    localparam int AW = $clog2(DEPTH);

    logic [AW:0] w_sum;

    // map a logical index to a ring slot: one add, one compare and subtract
    always_comb begin
        w_sum = {1'b0, i_head} + {1'b0, i_index};
        if (w_sum >= (AW+1)'(DEPTH)) begin
            w_sum = w_sum - (AW+1)'(DEPTH);
        end
        o_slot = w_sum[AW-1:0];
    end

endmodule

`default_nettype wire

[verif/tb_bounded_deque_with_search.sv]
`default_nettype none

module tb_bounded_deque_with_search;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int          RING_DEPTH       = DEF_DEPTH;
    localparam int          SCRIPT_LEN       = 23;
    localparam int          RANDOM_PER_PHASE = 275;
    localparam int          CYCLE_LIMIT      = 500000;
    localparam int          DRAIN_CYCLES     = 100;
    // request codes the block ignores
    localparam logic [3:0]  CMD_UNUSED_LO    = 4'd9;
    localparam logic [3:0]  CMD_UNUSED_HI    = 4'd15;

    typedef struct packed {
        logic [31:0] data_out;
        logic [5:0]  found_index;
        t_status     status;
        logic [6:0]  entry_count;
    } deque_reply_t;

    typedef struct packed {
        logic [3:0]   cmd;
        logic [31:0]  value;
        logic [6:0]   pos;
        logic         has_fixed;
        deque_reply_t fixed_reply;
    } script_row_t;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } run_mode_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [3:0]  i_cmd         = CMD_CLEAR;
    logic [31:0] i_data_in     = '0;
    logic [6:0]  i_position    = '0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_data_out;
    logic [5:0]  o_found_index;
    logic [2:0]  o_status;
    logic [6:0]  o_entry_count;

    // shadow copy of the deque
    logic [31:0] shadow_ring [RING_DEPTH];
    int          shadow_head  = 0;
    int          shadow_count = 0;

    deque_reply_t owed_replies [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int unsigned  send_idle_pct  = 0;
    int unsigned  stall_pct      = 0;
    int unsigned  idle_of_phase  [4] = '{0, 77, 0, 7};
    int unsigned  stall_of_phase [4] = '{0, 0, 77, 7};

    // directed requests; a fixed reply is given where it is plain to see
    script_row_t script [SCRIPT_LEN] = '{
        '{CMD_POP_BACK,   32'd0,        7'd0,  1'b1, '{32'd0, 6'd0, STAT_EMPTY,  7'd0}},
        '{CMD_POP_FRONT,  32'd0,        7'd0,  1'b1, '{32'd0, 6'd0, STAT_EMPTY,  7'd0}},
        '{CMD_FIND_FRONT, 32'd5,        7'd0,  1'b1, '{32'd0, 6'd0, STAT_EMPTY,  7'd0}},
        '{CMD_FIND_BACK,  32'd5,        7'd0,  1'b1, '{32'd0, 6'd0, STAT_EMPTY,  7'd0}},
        '{CMD_REMOVE,     32'd0,        7'd0,  1'b1, '{32'd0, 6'd0, STAT_EMPTY,  7'd0}},
        '{CMD_INSERT,     32'd9,        7'd1,  1'b1, '{32'd0, 6'd0, STAT_BADPOS, 7'd0}},
        '{CMD_PUSH_BACK,  32'h7FFFFFFF, 7'd0,  1'b1, '{32'd0, 6'd0, STAT_OK,     7'd1}},
        '{CMD_PUSH_FRONT, 32'h80000000, 7'd0,  1'b1, '{32'd0, 6'd0, STAT_OK,     7'd2}},
        '{CMD_INSERT,     32'hFFFFFFFF, 7'd2,  1'b1, '{32'd0, 6'd0, STAT_OK,     7'd3}},
        '{CMD_INSERT,     32'd0,        7'd0,  1'b0, '0},
        '{CMD_INSERT,     32'd1,        7'd64, 1'b1, '{32'd0, 6'd0, STAT_BADPOS, 7'd4}},
        '{CMD_FIND_FRONT, 32'h7FFFFFFF, 7'd0,  1'b0, '0},
        '{CMD_FIND_BACK,  32'd0,        7'd0,  1'b0, '0},
        '{CMD_FIND_FRONT, 32'd12345,    7'd0,  1'b0, '0},
        '{CMD_REMOVE,     32'd0,        7'd4,  1'b1, '{32'd0, 6'd0, STAT_BADPOS, 7'd4}},
        '{CMD_REMOVE,     32'd0,        7'd1,  1'b0, '0},
        '{CMD_POP_BACK,   32'd0,        7'd0,  1'b0, '0},
        '{CMD_POP_FRONT,  32'd0,        7'd0,  1'b0, '0},
        '{CMD_UNUSED_LO,  32'd7,        7'd3,  1'b1, '{32'd0, 6'd0, STAT_OK,     7'd1}},
        '{CMD_UNUSED_HI,  32'hFFFFFFFF, 7'd64, 1'b1, '{32'd0, 6'd0, STAT_OK,     7'd1}},
        '{CMD_CLEAR,      32'd0,        7'd0,  1'b1, '{32'd0, 6'd0, STAT_OK,     7'd0}},
        '{CMD_PUSH_FRONT, 32'd1,        7'd0,  1'b1, '{32'd0, 6'd0, STAT_OK,     7'd1}},
        '{CMD_CLEAR,      32'd0,        7'd0,  1'b1, '{32'd0, 6'd0, STAT_OK,     7'd0}}
    };

    bounded_deque_with_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_data_in     (i_data_in),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_out    (o_data_out),
        .o_found_index (o_found_index),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic int slot_at(input int idx);
        return (shadow_head + idx) % RING_DEPTH;
    endfunction

    // advance the shadow deque by one request and return its reply
    function automatic deque_reply_t deque_reply_for(input logic [3:0] cmd,
                                                     input logic [31:0] value,
                                                     input logic [6:0] pos);
        deque_reply_t reply;
        int           i;
        reply.data_out    = '0;
        reply.found_index = '0;
        reply.status      = STAT_OK;
        case (cmd)
            CMD_PUSH_BACK: begin
                if (shadow_count >= RING_DEPTH) begin
                    reply.status = STAT_FULL;
                end else begin
                    shadow_ring[slot_at(shadow_count)] = value;
                    shadow_count++;
                end
            end
            CMD_PUSH_FRONT: begin
                if (shadow_count >= RING_DEPTH) begin
                    reply.status = STAT_FULL;
                end else begin
                    shadow_head = (shadow_head + RING_DEPTH - 1) % RING_DEPTH;
                    shadow_ring[shadow_head] = value;
                    shadow_count++;
                end
            end
            CMD_POP_BACK: begin
                if (shadow_count == 0) begin
                    reply.status = STAT_EMPTY;
                end else begin
                    reply.data_out = shadow_ring[slot_at(shadow_count - 1)];
                    shadow_count--;
                end
            end
            CMD_POP_FRONT: begin
                if (shadow_count == 0) begin
                    reply.status = STAT_EMPTY;
                end else begin
                    reply.data_out = shadow_ring[shadow_head];
                    shadow_head    = (shadow_head + 1) % RING_DEPTH;
                    shadow_count--;
                end
            end
            CMD_FIND_FRONT: begin
                if (shadow_count == 0) begin
                    reply.status = STAT_EMPTY;
                end else begin
                    reply.status = STAT_NOTFOUND;
                    for (i = 0; i < shadow_count; i++) begin
                        if (shadow_ring[slot_at(i)] == value) begin
                            reply.found_index = i[5:0];
                            reply.status      = STAT_OK;
                            break;
                        end
                    end
                end
            end
            CMD_FIND_BACK: begin
                if (shadow_count == 0) begin
                    reply.status = STAT_EMPTY;
                end else begin
                    // scan down to and including the front entry
                    reply.status = STAT_NOTFOUND;
                    for (i = shadow_count - 1; i >= 0; i--) begin
                        if (shadow_ring[slot_at(i)] == value) begin
                            reply.found_index = i[5:0];
                            reply.status      = STAT_OK;
                            break;
                        end
                    end
                end
            end
            CMD_REMOVE: begin
                if (shadow_count == 0) begin
                    reply.status = STAT_EMPTY;
                end else if (int'(pos) >= shadow_count) begin
                    reply.status = STAT_BADPOS;
                end else begin
                    reply.data_out = shadow_ring[slot_at(pos)];
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_ring[slot_at(i)] = shadow_ring[slot_at(i + 1)];
                    shadow_count--;
                end
            end
            CMD_INSERT: begin
                // fullness wins over a bad position
                if (shadow_count >= RING_DEPTH) begin
                    reply.status = STAT_FULL;
                end else if (int'(pos) > shadow_count) begin
                    reply.status = STAT_BADPOS;
                end else begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_ring[slot_at(i)] = shadow_ring[slot_at(i - 1)];
                    shadow_ring[slot_at(pos)] = value;
                    shadow_count++;
                end
            end
            CMD_CLEAR: begin
                shadow_count = 0;
                shadow_head  = 0;
            end
            default: begin
            end
        endcase
        reply.entry_count = shadow_count[6:0];
        return reply;
    endfunction

    // offer one request, wait for acceptance and record what it owes
    task automatic send_request(input logic [3:0] cmd, input logic [31:0] value,
                                input logic [6:0] pos, input logic has_fixed,
                                input deque_reply_t fixed_reply);
        deque_reply_t reply;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_data_in  <= value;
        i_position <= pos;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        reply = deque_reply_for(cmd, value, pos);
        owed_replies.push_back(has_fixed ? fixed_reply : reply);
    endtask

    // small values repeat often so that searches hit
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'h00000000;
            3:       return 32'hFFFFFFFF;
            4, 5, 6: return 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [6:0] pick_position();
        if ($urandom_range(99) < 85)
            return 7'($urandom_range(shadow_count));
        return 7'($urandom_range(RING_DEPTH));
    endfunction

    function automatic run_mode_t pick_mode();
        case ($urandom_range(2))
            0:       return MODE_FILL;
            1:       return MODE_DRAIN;
            default: return MODE_MIXED;
        endcase
    endfunction

    function automatic logic [3:0] pick_cmd(input run_mode_t mode);
        int unsigned r;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL: begin
                if (r < 35) return CMD_PUSH_BACK;
                if (r < 70) return CMD_PUSH_FRONT;
                if (r < 85) return CMD_INSERT;
                if (r < 89) return CMD_FIND_FRONT;
                if (r < 93) return CMD_FIND_BACK;
                if (r < 97) return (r < 95) ? CMD_POP_BACK : CMD_POP_FRONT;
                return CMD_REMOVE;
            end
            MODE_DRAIN: begin
                if (r < 18) return CMD_POP_BACK;
                if (r < 35) return CMD_POP_FRONT;
                if (r < 60) return CMD_REMOVE;
                if (r < 70) return CMD_FIND_FRONT;
                if (r < 80) return CMD_FIND_BACK;
                if (r < 90) return (r < 85) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                return CMD_INSERT;
            end
            default: begin
                if (r < 2)  return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                if (r < 5)  return CMD_CLEAR;
                if (r < 17) return CMD_PUSH_BACK;
                if (r < 29) return CMD_PUSH_FRONT;
                if (r < 40) return CMD_POP_BACK;
                if (r < 51) return CMD_POP_FRONT;
                if (r < 63) return CMD_FIND_FRONT;
                if (r < 75) return CMD_FIND_BACK;
                if (r < 88) return CMD_REMOVE;
                return CMD_INSERT;
            end
        endcase
    endfunction

    // check each reply against the oldest owed one, then pick the next stall
    always @(posedge i_clk) begin
        deque_reply_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_replies.size() == 0) begin
                $error("reply with no request pending: data_out=%h status=%0d",
                       o_data_out, o_status);
                mismatch_count++;
            end else begin
                want = owed_replies.pop_front();
                if (o_data_out !== want.data_out) begin
                    $error("data_out: expected %h, got %h", want.data_out, o_data_out);
                    mismatch_count++;
                end
                if (o_found_index !== want.found_index) begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, o_found_index);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, o_entry_count);
                    mismatch_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // drop the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_bounded_deque_with_search: FAIL");
            $finish;
        end
    end

    initial begin
        int          row;
        int          phase;
        int          sent;
        int          run_len;
        int          k;
        run_mode_t   mode;
        logic [3:0]  cmd;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        for (row = 0; row < SCRIPT_LEN; row++)
            send_request(script[row].cmd, script[row].value, script[row].pos,
                         script[row].has_fixed, script[row].fixed_reply);

        // random runs under each idling pattern
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = idle_of_phase[phase];
            stall_pct     = stall_of_phase[phase];
            sent          = 0;
            while (sent < RANDOM_PER_PHASE) begin
                // open with a long fill so the full cases show up early
                if (phase == 0 && sent == 0) begin
                    mode    = MODE_FILL;
                    run_len = 110;
                end else begin
                    mode    = pick_mode();
                    run_len = $urandom_range(10, 80);
                end
                for (k = 0; k < run_len && sent < RANDOM_PER_PHASE; k++) begin
                    cmd = pick_cmd(mode);
                    send_request(cmd, pick_value(), pick_position(), 1'b0, '0);
                    if (cmd <= CMD_CLEAR)
                        sent++;
                end
            end
        end
        i_in_valid <= 1'b0;

        // wait out the owed replies and watch for strays
        while (owed_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_bounded_deque_with_search: PASS");
        end else begin
            $display("tb_bounded_deque_with_search: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/bdq_pkg.sv
rtl/core/bdq_ram.sv
rtl/core/bdq_slot.sv
rtl/core/bounded_deque_with_search.sv
verif/tb_bounded_deque_with_search.sv
